// ===== hdl/u2d_pkg.sv =====
// u2d_pkg: types, constants and stage functions for the decimal ascii converter
// no dependencies; used by the channel interfaces and u32_to_decimal_ascii
`default_nettype none

package u2d_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHARS_LO_W  = 64;
  localparam int CHARS_HI_W  = 16;
  localparam int COUNT_W     = 4;
  localparam int NUM_CHARS   = 10;
  localparam int NUM_PAIRS   = 5;
  localparam int FRAC_W      = 32;
  localparam int PROD_W      = 64;
  localparam int T0_W        = 38;
  localparam int T1_W        = 59;
  localparam int TP_W        = 39;
  localparam int POW_W       = 27;
  localparam int RECIP_SHIFT = 26;

  localparam logic [VALUE_W-1:0] RECIP_1E8 = 32'd2882303761;
  localparam logic [T0_W-1:0]    ROUND_ADD = 38'd40;
  localparam logic [TP_W-1:0]    MUL_100   = 39'd100;
  localparam logic [6:0]         PAIR_MAX  = 7'd99;
  localparam logic [7:0]         ASCII_ZERO = 8'h30;

  typedef logic [2:0]               est_t;
  typedef logic [NUM_CHARS-1:0][7:0] text_t;

  typedef struct packed {
    logic              zero;
    est_t              est;
    logic [PROD_W-1:0] prod;
  } mul_stage_t;

  typedef struct packed {
    logic            zero;
    est_t            est;
    logic [T0_W-1:0] t;
  } add_stage_t;

  typedef struct packed {
    logic            zero;
    est_t            est;
    logic [T1_W-1:0] t;
  } scale_stage_t;

  typedef struct packed {
    logic [TP_W-1:0]    t;
    logic [2:0]         pairs;
    logic [COUNT_W-1:0] pos;
    text_t              text;
  } pair_stage_t;

  // digit pair estimate from the position of the leading one
  function automatic est_t estimate_pairs(input logic [VALUE_W-1:0] v);
    est_t e;
    if (v[31:26] != '0) e = 3'd4;
    else if (v[25:19] != '0) e = 3'd3;
    else if (v[18:13] != '0) e = 3'd2;
    else if (v[12:6] != '0) e = 3'd1;
    else e = 3'd0;
    return e;
  endfunction

  function automatic logic [POW_W-1:0] pow_of(input est_t e);
    logic [POW_W-1:0] p;
    unique case (e)
      3'd0:    p = 27'd100000000;
      3'd1:    p = 27'd1000000;
      3'd2:    p = 27'd10000;
      default: p = 27'd100;
    endcase
    return p;
  endfunction

  // write one character at pos; positions past the end are dropped
  function automatic text_t put_char(input text_t text, input logic [COUNT_W-1:0] pos,
                                     input logic [7:0] c);
    text_t r;
    r = text;
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (pos == COUNT_W'(i)) r[i] = c;
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] bump_pos(input logic [COUNT_W-1:0] pos);
    logic [COUNT_W-1:0] r;
    if (pos < COUNT_W'(NUM_CHARS)) r = pos + 4'd1;
    else r = pos;
    return r;
  endfunction

  // leading single digit when the integer part is below ten
  function automatic pair_stage_t first_step(input scale_stage_t s);
    logic [T1_W-FRAC_W-1:0] first;
    pair_stage_t r;
    first = s.t[T1_W-1:FRAC_W];
    r.text = '0;
    r.pos = '0;
    if (first < 27'd10) begin
      if (first != '0 || s.zero) begin
        r.text = put_char(r.text, r.pos, ASCII_ZERO + 8'(first));
        r.pos = 4'd1;
      end
      r.t = {7'd0, s.t[FRAC_W-1:0]} * MUL_100;
      r.pairs = s.est;
    end else begin
      // saturate the integer part, the pair step clamps it to 99 anyway
      r.t = {(first > 27'(PAIR_MAX)) ? PAIR_MAX : first[6:0], s.t[FRAC_W-1:0]};
      r.pairs = s.est + 3'd1;
    end
    return r;
  endfunction

  function automatic pair_stage_t pair_step(input pair_stage_t s);
    logic [6:0]  q;
    logic [14:0] q_scaled;
    logic [3:0]  tens;
    logic [3:0]  ones;
    pair_stage_t r;
    r = s;
    if (s.pairs != '0) begin
      q = s.t[TP_W-1:FRAC_W];
      if (q > PAIR_MAX) q = PAIR_MAX;
      q_scaled = {8'd0, q} * 15'd205;
      tens = q_scaled[14:11];
      ones = 4'(q - 7'(tens) * 7'd10);
      r.text = put_char(s.text, s.pos, ASCII_ZERO + 8'(tens));
      r.pos = bump_pos(s.pos);
      r.text = put_char(r.text, r.pos, ASCII_ZERO + 8'(ones));
      r.pos = bump_pos(r.pos);
      r.t = {7'd0, s.t[FRAC_W-1:0]} * MUL_100;
      r.pairs = s.pairs - 3'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/u2d_if.sv =====
// u2d_in_if / u2d_out_if: valid-ready channels for the decimal ascii converter
// depends on u2d_pkg for payload widths
`default_nettype none

interface u2d_in_if import u2d_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface u2d_out_if import u2d_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CHARS_LO_W-1:0] chars_first_eight;
  logic [CHARS_HI_W-1:0] chars_last_two;
  logic [COUNT_W-1:0]    digit_count;

  modport source (output valid, output chars_first_eight, output chars_last_two,
                  output digit_count, input ready);
  modport sink   (input valid, input chars_first_eight, input chars_last_two,
                  input digit_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/u32_to_decimal_ascii.sv =====
// u32_to_decimal_ascii: 32-bit unsigned to decimal ascii text, no leading zeros
// depends on u2d_pkg and the channel interfaces in u2d_if.sv
// Accepts one value per cycle unless stalled and returns one result per value, in
// order. Stages: a 32x32 reciprocal multiply, the rounding add, a 32x27 multiply
// by a power of ten (bypassed for the largest estimate), the leading single digit,
// then five pair stages that each take two digits with a multiply by 100. While the
// result register is full and not taken, the whole pipeline holds and ready is low.
`default_nettype none

module u32_to_decimal_ascii import u2d_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  u2d_in_if.sink     in_ch,
  u2d_out_if.source  out_ch
);

  logic         adv;
  logic         vld_mul, vld_add, vld_scale;
  logic [NUM_PAIRS:0] pvld;
  mul_stage_t   s_mul;
  add_stage_t   s_add;
  scale_stage_t s_scale;
  pair_stage_t  pst [0:NUM_PAIRS];

  assign adv = !pvld[NUM_PAIRS] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_mul   <= 1'b0;
      vld_add   <= 1'b0;
      vld_scale <= 1'b0;
      pvld[0]   <= 1'b0;
    end else if (adv) begin
      vld_mul   <= in_ch.valid;
      vld_add   <= vld_mul;
      vld_scale <= vld_add;
      pvld[0]   <= vld_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_mul.zero <= (in_ch.value == '0);
      s_mul.est  <= estimate_pairs(in_ch.value);
      s_mul.prod <= {32'd0, in_ch.value} * {32'd0, RECIP_1E8};

      s_add.zero <= s_mul.zero;
      s_add.est  <= s_mul.est;
      s_add.t    <= T0_W'(s_mul.prod >> RECIP_SHIFT) + ROUND_ADD;

      s_scale.zero <= s_add.zero;
      s_scale.est  <= s_add.est;
      if (s_add.est < 3'd4) begin
        s_scale.t <= {27'd0, s_add.t[FRAC_W-1:0]} * {32'd0, pow_of(s_add.est)};
      end else begin
        s_scale.t <= {21'd0, s_add.t};
      end

      pst[0] <= first_step(s_scale);
    end
  end

  for (genvar k = 1; k <= NUM_PAIRS; k++) begin : g_pair
    always_ff @(posedge clk) begin
      if (rst) begin
        pvld[k] <= 1'b0;
      end else if (adv) begin
        pvld[k] <= pvld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pst[k] <= pair_step(pst[k-1]);
      end
    end
  end

  assign out_ch.valid             = pvld[NUM_PAIRS];
  assign out_ch.chars_first_eight = pst[NUM_PAIRS].text[7:0];
  assign out_ch.chars_last_two    = pst[NUM_PAIRS].text[9:8];
  assign out_ch.digit_count       = pst[NUM_PAIRS].pos;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.digit_count != 4'd0 && out_ch.digit_count <= 4'd10))
    else $error("digit count out of range");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.digit_count > 4'd1) |-> (out_ch.chars_first_eight[7:0] != ASCII_ZERO))
    else $error("leading zero in multi-digit result");

  a_short_tail_clear: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.digit_count < 4'd9) |-> (out_ch.chars_last_two == '0))
    else $error("unused character positions not zero");

endmodule

`default_nettype wire

// ===== tb/sv/u32_to_decimal_ascii_tb.sv =====
// u32_to_decimal_ascii_tb: self-checking testbench for the decimal ascii converter
// depends on u2d_pkg, u2d_in_if / u2d_out_if and u32_to_decimal_ascii
// named test tasks drive values, a posedge process checks each result in order
module u32_to_decimal_ascii_tb;
  import u2d_pkg::*;

  localparam int          CLK_HALF    = 6;
  localparam int          RESET_LEN   = 8;
  localparam int          IDLE_PCT    = 30;
  localparam int          HOLD_CYCLES = 150;
  localparam int          DRAIN_LIMIT = 5000;
  localparam int          SETTLE_LEN  = 20;
  localparam int          MAX_REPORTS = 10;
  localparam int unsigned LOG_MUL     = 77;
  localparam int unsigned LOG_SHIFT   = 9;

  typedef struct packed {
    logic [CHARS_LO_W-1:0] chars_lo;
    logic [CHARS_HI_W-1:0] chars_hi;
    logic [COUNT_W-1:0]    count;
  } decimal_text_t;

  logic clk;
  logic rst;
  logic idle_on;
  logic hold_requested;
  int   mismatch_count;

  decimal_text_t pending_text[$];

  u2d_in_if  in_ch ();
  u2d_out_if out_ch ();

  u32_to_decimal_ascii u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    #(2 * CLK_HALF * 400000);
    $display("status: fail");
    $finish;
  end

  function automatic logic idle_roll();
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // decimal text of v: reciprocal scale, then a leading digit when below ten and two-digit steps
  function automatic decimal_text_t decimal_text_of(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] v_or1;
    int unsigned        nbits;
    int unsigned        est;
    int                 pairs;
    logic [63:0]        t;
    logic [63:0]        lead;
    logic [63:0]        q;
    logic [3:0]         digits[$];
    text_t              txt;
    decimal_text_t      r;
    v_or1 = v | 32'd1;
    nbits = 0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (v_or1[i]) nbits = i + 1;
    end
    est = (nbits * LOG_MUL) >> LOG_SHIFT;
    t = ((64'(v) * 64'(RECIP_1E8)) >> RECIP_SHIFT) + 64'(ROUND_ADD);
    case (est)
      0: t = 64'(t[FRAC_W-1:0]) * 64'd100000000;
      1: t = 64'(t[FRAC_W-1:0]) * 64'd1000000;
      2: t = 64'(t[FRAC_W-1:0]) * 64'd10000;
      3: t = 64'(t[FRAC_W-1:0]) * 64'd100;
      default: ;
    endcase
    pairs = est + 1;
    lead = t >> FRAC_W;
    // estimate one pair high or odd digit count: emit a single leading digit
    if (lead < 10) begin
      if (lead != 0 || v == '0) digits.push_back(lead[3:0]);
      t = 64'(t[FRAC_W-1:0]) * 64'd100;
      pairs--;
    end
    while (pairs > 0) begin
      q = t >> FRAC_W;
      if (q > 99) q = 99;
      digits.push_back(4'(q / 10));
      digits.push_back(4'(q % 10));
      t = 64'(t[FRAC_W-1:0]) * 64'd100;
      pairs--;
    end
    txt = '0;
    for (int i = 0; i < digits.size() && i < NUM_CHARS; i++) begin
      txt[i] = ASCII_ZERO + 8'(digits[i]);
    end
    r.chars_lo = txt[7:0];
    r.chars_hi = txt[9:8];
    r.count = (digits.size() > NUM_CHARS) ? COUNT_W'(NUM_CHARS) : COUNT_W'(digits.size());
    return r;
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    while (idle_on && idle_roll()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    pending_text.push_back(decimal_text_of(v));
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_requested) begin
        hold_requested = 1'b0;
        out_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end else begin
        out_ch.ready <= !(idle_on && idle_roll());
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    decimal_text_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_text.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected transaction: chars %h %h count %0d",
                   out_ch.chars_first_eight, out_ch.chars_last_two, out_ch.digit_count);
      end else begin
        want = pending_text.pop_front();
        if (out_ch.chars_first_eight !== want.chars_lo ||
            out_ch.chars_last_two !== want.chars_hi ||
            out_ch.digit_count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected %h %h count %0d, got %h %h count %0d",
                     want.chars_lo, want.chars_hi, want.count,
                     out_ch.chars_first_eight, out_ch.chars_last_two,
                     out_ch.digit_count);
        end
      end
    end
  end

  task automatic test_decimal_boundaries();
    logic [VALUE_W-1:0] vals[$];
    vals = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
             32'd9999, 32'd10000, 32'd99999999, 32'd100000000, 32'd999999999,
             32'd1000000000, 32'hFFFFFFFF};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // values on both sides of each step of the pair estimate, plus bit patterns
  task automatic test_estimate_boundaries();
    logic [VALUE_W-1:0] vals[$];
    vals = '{32'd63, 32'd64, 32'd8191, 32'd8192, 32'd524287, 32'd524288,
             32'd67108863, 32'd67108864, 32'hAAAAAAAA, 32'h55555555};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random_widths(input int count);
    logic [63:0] lo;
    logic [63:0] hi;
    int          d;
    for (int n = 0; n < count; n++) begin
      if (n % 2 == 0) begin
        send_value($urandom >> $urandom_range(31));
      end else begin
        d = $urandom_range(10, 1);
        lo = 1;
        for (int k = 1; k < d; k++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'hFFFFFFFF) hi = 64'hFFFFFFFF;
        send_value(lo[31:0] + $urandom_range(32'(hi - lo), 0));
      end
    end
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    for (int n = 0; n < count; n++) send_value($urandom >> $urandom_range(31));
    idle_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, filling the pipeline
  task automatic test_output_backpressure(input int count);
    idle_on = 1'b0;
    hold_requested = 1'b1;
    for (int n = 0; n < count; n++) send_value($urandom);
    idle_on = 1'b1;
  endtask

  task automatic test_random_full_range(input int count);
    for (int n = 0; n < count; n++) send_value($urandom);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    idle_on = 1'b1;
    hold_requested = 1'b0;
    mismatch_count = 0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (RESET_LEN) @(negedge clk);
    rst <= 1'b0;

    test_decimal_boundaries();
    test_estimate_boundaries();
    test_random_widths(500);
    test_back_to_back(300);
    test_output_backpressure(60);
    test_random_full_range(515);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && pending_text.size() > 0; n++) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
    if (mismatch_count == 0 && pending_text.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/u2d_pkg.sv
hdl/u2d_if.sv
hdl/u32_to_decimal_ascii.sv
tb/sv/u32_to_decimal_ascii_tb.sv
